@@ design/nlc_pkg.sv @@
package nlc_pkg;

    // Field widths
    localparam int VALUE_W    = 27;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 8;
    localparam int DIGIT_W    = 4;
    // Decimal digits needed to hold any VALUE_W-bit number
    localparam int BCD_DIGITS = 9;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    // Position of a write within one transaction's output burst
    localparam int EMIT_IDX_W = 4;

    localparam int DIGITS_DEFAULT = 8;

    // Input kind codes
    localparam logic KIND_SETUP  = 1'b0;
    localparam logic KIND_NUMBER = 1'b1;

    // Driver register addresses
    localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
    localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
    localparam logic [ADDR_W-1:0] ADDR_SCAN      = 4'hB;
    localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'hF;

    // Set-up data bytes
    localparam logic [DATA_W-1:0] DATA_DECODE_ALL = 8'hFF;
    localparam logic [DATA_W-1:0] DATA_INTENSITY  = 8'h09;
    localparam logic [DATA_W-1:0] DATA_SCAN_ALL   = 8'h07;
    localparam logic [DATA_W-1:0] DATA_NORMAL_OP  = 8'h01;
    localparam logic [DATA_W-1:0] DATA_TEST_OFF   = 8'h00;

    localparam int SETUP_WRITES = 5;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

    typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    // Status of the shift-and-adjust converter
    typedef struct packed {
        logic busy;
        bcd_t digits;
    } dab_status_t;

    // Address of the set-up write at a given position
    function automatic logic [ADDR_W-1:0] setup_addr(input logic [2:0] idx);
        logic [ADDR_W-1:0] a;
        unique case (idx)
            3'd0:    a = ADDR_DECODE;
            3'd1:    a = ADDR_INTENSITY;
            3'd2:    a = ADDR_SCAN;
            3'd3:    a = ADDR_SHUTDOWN;
            default: a = ADDR_TEST;
        endcase
        return a;
    endfunction

    // Data of the set-up write at a given position
    function automatic logic [DATA_W-1:0] setup_data(input logic [2:0] idx);
        logic [DATA_W-1:0] d;
        unique case (idx)
            3'd0:    d = DATA_DECODE_ALL;
            3'd1:    d = DATA_INTENSITY;
            3'd2:    d = DATA_SCAN_ALL;
            3'd3:    d = DATA_NORMAL_OP;
            default: d = DATA_TEST_OFF;
        endcase
        return d;
    endfunction

endpackage

@@ design/nlc_dabble.sv @@
module nlc_dabble (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [nlc_pkg::VALUE_W-1:0]     value,
    output nlc_pkg::dab_status_t            status
);

    localparam int STEP_W = $clog2(nlc_pkg::VALUE_W + 1);

    logic [nlc_pkg::VALUE_W-1:0] bin_reg, bin_next;
    nlc_pkg::bcd_t               bcd_reg, bcd_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;

    nlc_pkg::bcd_t               adj;
    logic [nlc_pkg::BCD_W-1:0]   adj_flat;

    // Add three to every digit of five or more
    always_comb begin
        for (int i = 0; i < nlc_pkg::BCD_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        adj_flat = adj;
    end

    // Load on start, otherwise while busy shift one binary bit into the digits per cycle
    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            bin_next  = value;
            bcd_next  = '0;
            step_next = STEP_W'(nlc_pkg::VALUE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next  = {adj_flat[nlc_pkg::BCD_W-2:0], bin_reg[nlc_pkg::VALUE_W-1]};
            bin_next  = {bin_reg[nlc_pkg::VALUE_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            busy_next = (step_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy   = busy_reg;
    assign status.digits = bcd_reg;

endmodule

@@ design/number_to_led_digit_commands_unit.sv @@
// Number to display-driver command sequencer.
// Input channel s_*: one transaction carries s_kind and s_value. Kind 0 asks
// for the five-write driver set-up (decode all, intensity 9, scan limit 7,
// normal operation, display test off). Kind 1 shows s_value: a scan-limit
// write of digit count minus one, then one write per decimal digit, least
// significant first, to digit registers 1 upward. Values of 10^DIGITS or
// more show as DIGITS nines.
// Output channel m_*: one register write per transaction, m_last marks the
// final write caused by an input transaction.
// A number is accepted, shifted through the shift-and-adjust converter
// (one binary bit per cycle), has its digits counted and registered, then
// emits its writes in order. A set-up request is accepted, then emits its
// set-up writes in order. s_ready is high only while no transaction is
// in progress; it rises once the final write is in the output register.
// A stalled receiver holds the output register and the sequence pauses.
// Reset (aresetn low, synchronous) empties the output register and returns
// the sequencer to idle.
module number_to_led_digit_commands_unit #(
    parameter int DIGITS = nlc_pkg::DIGITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [nlc_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [nlc_pkg::ADDR_W-1:0]    m_reg_address,
    output logic [nlc_pkg::DATA_W-1:0]    m_reg_data,
    output logic                          m_last
);

    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam int IDX_W = nlc_pkg::EMIT_IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic                        kind_reg, kind_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        sat_reg, sat_next;
    logic                        m_valid_reg, m_valid_next;
    logic [nlc_pkg::ADDR_W-1:0]  m_addr_reg, m_addr_next;
    logic [nlc_pkg::DATA_W-1:0]  m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    logic                        dab_start;
    nlc_pkg::dab_status_t        dab_status;

    logic [CNT_W-1:0]            cnt_calc;
    logic                        ovf_calc;
    logic                        out_free;
    logic [IDX_W-1:0]            idx_m1;
    logic [nlc_pkg::DIGIT_W-1:0] digit_sel;

    assign s_ready   = (state_reg == ST_IDLE);
    assign dab_start = s_valid && s_ready && (s_kind == nlc_pkg::KIND_NUMBER);

    nlc_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dab_start),
        .value   (s_value),
        .status  (dab_status)
    );

    // Count digits and detect values too wide for the display
    always_comb begin
        cnt_calc = CNT_W'(1);
        ovf_calc = 1'b0;
        for (int i = 1; i < DIGITS; i++) begin
            if (dab_status.digits[i] != '0) begin
                cnt_calc = CNT_W'(i + 1);
            end
        end
        for (int i = DIGITS; i < nlc_pkg::BCD_DIGITS; i++) begin
            if (dab_status.digits[i] != '0) begin
                ovf_calc = 1'b1;
            end
        end
        if (ovf_calc) begin
            cnt_calc = CNT_W'(DIGITS);
        end
    end

    // Pick the digit for the current digit register
    assign idx_m1    = idx_reg - IDX_W'(1);
    assign digit_sel = sat_reg ? nlc_pkg::DIGIT_NINE : dab_status.digits[idx_m1];
    assign out_free  = !m_valid_reg || m_ready;

    // Sequencer and output register
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg;
        m_addr_next  = m_addr_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    idx_next   = '0;
                    state_next = (s_kind == nlc_pkg::KIND_SETUP) ? ST_EMIT : ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (!dab_status.busy) begin
                    count_next = cnt_calc;
                    sat_next   = ovf_calc;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    idx_next     = idx_reg + IDX_W'(1);
                    if (kind_reg == nlc_pkg::KIND_SETUP) begin
                        m_addr_next = nlc_pkg::setup_addr(idx_reg[2:0]);
                        m_data_next = nlc_pkg::setup_data(idx_reg[2:0]);
                        m_last_next = (idx_reg == IDX_W'(nlc_pkg::SETUP_WRITES - 1));
                    end else if (idx_reg == '0) begin
                        m_addr_next = nlc_pkg::ADDR_SCAN;
                        m_data_next = {{(nlc_pkg::DATA_W - CNT_W){1'b0}},
                                       count_reg - CNT_W'(1)};
                        m_last_next = 1'b0;
                    end else begin
                        m_addr_next = idx_reg;
                        m_data_next = {{(nlc_pkg::DATA_W - nlc_pkg::DIGIT_W){1'b0}},
                                       digit_sel};
                        m_last_next = (idx_reg == IDX_W'(count_reg));
                    end
                    if (m_last_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
        kind_reg   <= kind_next;
        count_reg  <= count_next;
        sat_reg    <= sat_next;
        m_addr_reg <= m_addr_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_address = m_addr_reg;
    assign m_reg_data    = m_data_reg;
    assign m_last        = m_last_reg;

endmodule

@@ design/nlc_checker.sv @@
module nlc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [nlc_pkg::ADDR_W-1:0]    m_reg_address,
    input logic [nlc_pkg::DATA_W-1:0]    m_reg_data,
    input logic                          m_last
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Hold a stalled write
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reg_address)
                                && $stable(m_reg_data) && $stable(m_last))
        else $error("stalled write changed");

    // Drop ready after a transaction is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

    // Digit registers only ever get decimal digits
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_address <= 4'd8 |-> m_reg_address != 4'd0 && m_reg_data <= 8'd9)
        else $error("bad digit write");

    // Scan limit never reaches beyond the last digit register
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_address == nlc_pkg::ADDR_SCAN |-> m_reg_data <= 8'd7 && !m_last)
        else $error("bad scan limit write");

endmodule

bind number_to_led_digit_commands_unit nlc_checker u_nlc_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int DIGITS      = nlc_pkg::DIGITS_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 60;
    localparam int IDLE_PCT    = 11;

    typedef struct {
        logic [nlc_pkg::ADDR_W-1:0] addr;
        logic [nlc_pkg::DATA_W-1:0] data;
        logic                       last;
    } drv_write_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_kind = nlc_pkg::KIND_SETUP;
    logic [nlc_pkg::VALUE_W-1:0] s_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [nlc_pkg::ADDR_W-1:0]  m_reg_address;
    logic [nlc_pkg::DATA_W-1:0]  m_reg_data;
    logic                        m_last;

    drv_write_t pending_writes[$];
    int         error_count = 0;
    int         stall_cycles = 0;
    bit         no_idle = 1'b0;

    number_to_led_digit_commands_unit #(
        .DIGITS(DIGITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_address (m_reg_address),
        .m_reg_data    (m_reg_data),
        .m_last        (m_last)
    );

    // Clock: 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Queue one expected driver write
    function automatic void push_write(input logic [nlc_pkg::ADDR_W-1:0] addr,
                                       input logic [nlc_pkg::DATA_W-1:0] data,
                                       input logic last);
        drv_write_t w;
        w.addr = addr;
        w.data = data;
        w.last = last;
        pending_writes.push_back(w);
    endfunction

    // Work out the driver writes that one request causes
    function automatic void predict_commands(input logic kind,
                                             input logic [nlc_pkg::VALUE_W-1:0] value);
        longint unsigned ceiling;
        longint unsigned n;
        int              count;
        if (kind == nlc_pkg::KIND_SETUP) begin
            push_write(nlc_pkg::ADDR_DECODE, nlc_pkg::DATA_DECODE_ALL, 1'b0);
            push_write(nlc_pkg::ADDR_INTENSITY, nlc_pkg::DATA_INTENSITY, 1'b0);
            push_write(nlc_pkg::ADDR_SCAN, nlc_pkg::DATA_SCAN_ALL, 1'b0);
            push_write(nlc_pkg::ADDR_SHUTDOWN, nlc_pkg::DATA_NORMAL_OP, 1'b0);
            push_write(nlc_pkg::ADDR_TEST, nlc_pkg::DATA_TEST_OFF, 1'b1);
            return;
        end
        // Saturate to all nines beyond the display width
        ceiling = 1;
        for (int i = 0; i < DIGITS; i++)
            ceiling = ceiling * 10;
        n = value;
        if (n >= ceiling)
            n = ceiling - 1;
        count = 1;
        for (longint unsigned t = n; t / 10 != 0; t = t / 10)
            count++;
        push_write(nlc_pkg::ADDR_SCAN, nlc_pkg::DATA_W'(count - 1), 1'b0);
        // Least significant digit to register 1 upward
        for (int i = 0; i < count; i++) begin
            push_write(nlc_pkg::ADDR_W'(i + 1), nlc_pkg::DATA_W'(n % 10), i == count - 1);
            n = n / 10;
        end
    endfunction

    // Check each output transaction, predict on each input transaction
    always @(posedge aclk) begin
        drv_write_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: reg_address %0h reg_data %0h last %0b",
                       m_reg_address, m_reg_data, m_last);
                error_count++;
            end else begin
                w = pending_writes.pop_front();
                if (m_reg_address !== w.addr) begin
                    $error("reg_address: expected %0h, got %0h", w.addr, m_reg_address);
                    error_count++;
                end
                if (m_reg_data !== w.data) begin
                    $error("reg_data: expected %0h, got %0h", w.data, m_reg_data);
                    error_count++;
                end
                if (m_last !== w.last) begin
                    $error("last: expected %0b, got %0b", w.last, m_last);
                    error_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            predict_commands(s_kind, s_value);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Hand one request to the block; returns at the accepting edge
    task automatic send_request(input logic kind, input logic [nlc_pkg::VALUE_W-1:0] value);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Number of a random decimal length, sometimes zero or any 27-bit pattern
    function automatic logic [nlc_pkg::VALUE_W-1:0] random_number();
        int unsigned     pick;
        int unsigned     len;
        longint unsigned lo;
        longint unsigned hi;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 30)
            return nlc_pkg::VALUE_W'($urandom);
        len = $urandom_range(9, 1);
        hi = 1;
        for (int i = 0; i < len; i++)
            hi = hi * 10;
        lo = (len == 1) ? 0 : hi / 10;
        hi = hi - 1;
        if (hi > (64'd1 << nlc_pkg::VALUE_W) - 1)
            hi = (64'd1 << nlc_pkg::VALUE_W) - 1;
        return nlc_pkg::VALUE_W'(lo + $urandom_range(int'(hi - lo)));
    endfunction

    task automatic test_setup_sequence();
        send_request(nlc_pkg::KIND_SETUP, '0);
        send_request(nlc_pkg::KIND_SETUP, '1);
    endtask

    // Lengths one to eight at both ends of each decade
    task automatic test_digit_boundaries();
        longint unsigned p;
        p = 1;
        send_request(nlc_pkg::KIND_NUMBER, '0);
        for (int i = 0; i < DIGITS; i++) begin
            send_request(nlc_pkg::KIND_NUMBER, nlc_pkg::VALUE_W'(p));
            p = p * 10;
            send_request(nlc_pkg::KIND_NUMBER, nlc_pkg::VALUE_W'(p - 1));
        end
        send_request(nlc_pkg::KIND_NUMBER, nlc_pkg::VALUE_W'(12345678));
    endtask

    // Values too wide for the display
    task automatic test_saturation();
        send_request(nlc_pkg::KIND_NUMBER, nlc_pkg::VALUE_W'(100000000));
        send_request(nlc_pkg::KIND_NUMBER, nlc_pkg::VALUE_W'(123456789));
        send_request(nlc_pkg::KIND_NUMBER, '1);
    endtask

    task automatic test_random_requests(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10)
                send_request(nlc_pkg::KIND_SETUP, nlc_pkg::VALUE_W'($urandom));
            else
                send_request(nlc_pkg::KIND_NUMBER, random_number());
        end
    endtask

    // Hold both sides busy with no idling
    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        test_random_requests(n);
        no_idle = 1'b0;
    endtask

    // Stop the run when nothing moves for too long
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_setup_sequence();
        test_digit_boundaries();
        test_saturation();
        test_random_requests(100);
        test_back_to_back(40);
        test_random_requests(50);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
design/nlc_pkg.sv
design/nlc_dabble.sv
design/number_to_led_digit_commands_unit.sv
design/nlc_checker.sv
test/tb.sv
